// ----- rtl/csa_sgr_pkg.sv -----
// Types, slot layout and decode functions for the cell stream to ANSI SGR encoder.
package csa_sgr_pkg;

    localparam int REND_W     = 22;
    localparam int CHAR_W     = 8;
    localparam int NUM_CODES  = 10;
    localparam int SLOTS_PER_CODE = 4;

    localparam int SLOT_ESC   = 0;
    localparam int SLOT_LBR   = 1;
    localparam int SLOT_ZERO  = 2;
    localparam int SLOT_CODE0 = 3;
    localparam int SLOT_M     = SLOT_CODE0 + NUM_CODES * SLOTS_PER_CODE;
    localparam int SLOT_CHAR  = SLOT_M + 1;
    localparam int NUM_SLOTS  = SLOT_CHAR + 1;

    localparam int BLINK_BIT  = 18;
    localparam int BOLD_BIT   = 19;
    localparam int ULINE_BIT  = 20;
    localparam int REV_BIT    = 21;

    localparam logic [7:0] SGR_BOLD  = 8'd1;
    localparam logic [7:0] SGR_ULINE = 8'd4;
    localparam logic [7:0] SGR_BLINK = 8'd5;
    localparam logic [7:0] SGR_REV   = 8'd7;
    localparam logic [7:0] SGR_FG_EXT = 8'd38;
    localparam logic [7:0] SGR_BG_EXT = 8'd48;
    localparam logic [7:0] SGR_PAL    = 8'd5;
    localparam logic [7:0] FG_LO      = 8'd30;
    localparam logic [7:0] BG_LO      = 8'd40;

    localparam logic [7:0] CH_ESC   = 8'h1B;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_M     = 8'h6D;
    localparam logic [3:0] DIGIT_HI = 4'h3;

    typedef logic [REND_W-1:0]    rend_t;
    typedef logic [7:0]           byte_t;
    typedef logic [NUM_SLOTS-1:0] slot_vec_t;
    typedef byte_t [NUM_SLOTS-1:0] slot_bytes_t;
    typedef byte_t [NUM_CODES-1:0] code_vals_t;
    typedef logic [NUM_CODES-1:0] code_en_t;

    function automatic logic [11:0] to_bcd(input logic [7:0] v);
        logic [19:0] s;
        s = {12'd0, v};
        for (int i = 0; i < 8; i++) begin
            if (s[11:8] >= 4'd5) s[11:8] = s[11:8] + 4'd3;
            if (s[15:12] >= 4'd5) s[15:12] = s[15:12] + 4'd3;
            if (s[19:16] >= 4'd5) s[19:16] = s[19:16] + 4'd3;
            s = s << 1;
        end
        return s[19:8];
    endfunction

    function automatic logic basic_color(input logic [7:0] c, input logic [7:0] lo);
        return ((c >= lo) && (c < lo + 8'd8)) || (c == lo + 8'd9);
    endfunction

    function automatic code_en_t code_en(input rend_t r);
        code_en_t en;
        en[0] = r[BOLD_BIT];
        en[1] = r[ULINE_BIT];
        en[2] = r[BLINK_BIT];
        en[3] = r[REV_BIT];
        en[4] = r[8];
        en[5] = r[8];
        en[6] = r[8] | basic_color(r[7:0], FG_LO);
        en[7] = r[17];
        en[8] = r[17];
        en[9] = r[17] | basic_color(r[16:9], BG_LO);
        return en;
    endfunction

    function automatic code_vals_t code_vals(input rend_t r);
        code_vals_t v;
        v[0] = SGR_BOLD;
        v[1] = SGR_ULINE;
        v[2] = SGR_BLINK;
        v[3] = SGR_REV;
        v[4] = SGR_FG_EXT;
        v[5] = SGR_PAL;
        v[6] = r[7:0];
        v[7] = SGR_BG_EXT;
        v[8] = SGR_PAL;
        v[9] = r[16:9];
        return v;
    endfunction

    // Bytes still to send for one cell; the character slot is always set.
    function automatic slot_vec_t slot_present(input logic need, input rend_t r);
        slot_vec_t  p;
        code_en_t   en;
        code_vals_t v;
        logic       any;
        p   = '0;
        en  = code_en(r);
        v   = code_vals(r);
        any = 1'b0;
        if (need) begin
            p[SLOT_ESC] = 1'b1;
            p[SLOT_LBR] = 1'b1;
            p[SLOT_M]   = 1'b1;
            if (r == '0) begin
                p[SLOT_ZERO] = 1'b1;
            end else begin
                for (int k = 0; k < NUM_CODES; k++) begin
                    p[SLOT_CODE0 + SLOTS_PER_CODE*k]     = en[k] & any;
                    p[SLOT_CODE0 + SLOTS_PER_CODE*k + 1] = en[k] & (v[k] >= 8'd100);
                    p[SLOT_CODE0 + SLOTS_PER_CODE*k + 2] = en[k] & (v[k] >= 8'd10);
                    p[SLOT_CODE0 + SLOTS_PER_CODE*k + 3] = en[k];
                    any = any | en[k];
                end
            end
        end
        p[SLOT_CHAR] = 1'b1;
        return p;
    endfunction

    function automatic slot_bytes_t slot_bytes(input byte_t ch, input rend_t r);
        slot_bytes_t b;
        code_vals_t  v;
        logic [11:0] d;
        v = code_vals(r);
        b[SLOT_ESC]  = CH_ESC;
        b[SLOT_LBR]  = CH_LBR;
        b[SLOT_ZERO] = CH_ZERO;
        b[SLOT_M]    = CH_M;
        b[SLOT_CHAR] = ch;
        for (int k = 0; k < NUM_CODES; k++) begin
            d = to_bcd(v[k]);
            b[SLOT_CODE0 + SLOTS_PER_CODE*k]     = CH_SEMI;
            b[SLOT_CODE0 + SLOTS_PER_CODE*k + 1] = {DIGIT_HI, d[11:8]};
            b[SLOT_CODE0 + SLOTS_PER_CODE*k + 2] = {DIGIT_HI, d[7:4]};
            b[SLOT_CODE0 + SLOTS_PER_CODE*k + 3] = {DIGIT_HI, d[3:0]};
        end
        return b;
    endfunction

endpackage

// ----- rtl/cell_stream_to_ansi_sgr_top.sv -----
// Cell stream to ANSI SGR escape encoder, top level.
//
//  channel | dir | tdata (low bit up)                    | tuser      | tlast
//  s_      | in  | cell_char[7:0], rendition[29:8], pad  | first_cell | -
//  m_      | out | out_byte[7:0]                         | -          | last_of_run
//
//  A cell with an unchanged rendition sends one byte, its character; such cells
//  go back to back while m_tready holds. A cell with a new rendition or a frame
//  start sends 4 to 29 bytes, one at a time, from the single cell holding register feeding the output register.
//  m_tready reaches s_tready combinationally: a new cell is taken in the cycle the
//  previous cell's character byte moves out. Reset is synchronous, no sweep.
module cell_stream_to_ansi_sgr_top
    import csa_sgr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // cell_char[7:0], rendition[29:8], zero[31:30]
    input  logic        s_tuser,   // first_cell
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    rend_t       s_rend;
    byte_t       s_char;
    logic        s_accept;
    logic        need;

    logic        prev_valid_reg;
    rend_t       prev_rend_reg;
    logic        hold_valid_reg;
    byte_t       hold_char_reg;
    rend_t       hold_rend_reg;
    slot_vec_t   pend_reg;
    slot_vec_t   pend_next;
    logic        m_valid_reg;
    byte_t       m_data_reg;
    logic        m_last_reg;

    slot_vec_t   pick;
    slot_bytes_t bytes;
    byte_t       sel_byte;
    logic        move;
    logic        final_byte;

    assign s_rend   = s_tdata[CHAR_W +: REND_W];
    assign s_char   = s_tdata[CHAR_W-1:0];
    assign need     = s_tuser | ~prev_valid_reg | (s_rend != prev_rend_reg);

    assign pick       = pend_reg & (~pend_reg + slot_vec_t'(1));
    assign final_byte = pick[SLOT_CHAR];
    assign move       = hold_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready   = !hold_valid_reg || (move && final_byte);
    assign s_accept   = s_tvalid && s_tready;
    assign pend_next  = pend_reg & ~pick;

    assign bytes = slot_bytes(hold_char_reg, hold_rend_reg);

    always_comb begin
        sel_byte = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            sel_byte = sel_byte | (pick[i] ? bytes[i] : 8'd0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_valid_reg <= 1'b0;
            prev_rend_reg  <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_accept) begin
                prev_valid_reg <= 1'b1;
                prev_rend_reg  <= s_rend;
                hold_valid_reg <= 1'b1;
            end else if (move && final_byte) begin
                hold_valid_reg <= 1'b0;
            end
            if (move) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            hold_char_reg <= s_char;
            hold_rend_reg <= s_rend;
            pend_reg      <= slot_present(need, s_rend);
        end else if (move) begin
            pend_reg <= pend_next;
        end
        if (move) begin
            m_data_reg <= sel_byte;
            m_last_reg <= final_byte;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_char_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        hold_valid_reg |-> pend_reg[SLOT_CHAR])
        else $error("held cell lost its character byte");

    a_ready_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tready && hold_valid_reg) |-> $onehot(pend_reg))
        else $error("new cell taken while escape bytes remain");

    a_accept_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> hold_valid_reg)
        else $error("accepted cell not held");

    a_last_frees: assert property (@(posedge aclk) disable iff (!aresetn)
        (move && final_byte && !s_accept) |=> !hold_valid_reg)
        else $error("holding register not freed after character byte");

    a_move_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        move |=> (m_tvalid && (m_tlast == $past(final_byte))))
        else $error("output register not loaded on move");
`endif

endmodule
